### src/rgbc_pkg.sv
// Shared constants, register codes and types for the RGB zero-padded convolution block.
`default_nettype none

package rgbc_pkg;

   // Default configuration of the datapath
   localparam int KERNEL_SIZE_DEF = 3;
   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int COEF_BITS_DEF   = 12;

   // Fixed field widths
   localparam int PIX_W     = 8;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int ROW_W     = 12;
   localparam int OUT_COL_W = 11;
   localparam int DIM_W     = 12;
   localparam int CFG_W     = 60;
   localparam int CSR_IDX_W = 3;

   // Kernel coefficient packing: five 12-bit slots per bank
   localparam int SLOT_W         = 12;
   localparam int SLOTS_PER_BANK = 5;
   localparam int NUM_BANKS      = 5;

   // Fixed point and clamp
   localparam int FRAC_BITS = 8;
   localparam int PIX_MAX   = 255;

   // Register reset values
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd1;

   // Generic RAM default depth
   localparam int RAM_DEPTH_DEF = 512;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_A       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_B       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_C       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_D       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_E       = 3'd6;

   // Item opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Per-stage advance strobes for the multiply-accumulate pipeline
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } rgbc_pipe_en_type;

endpackage

`default_nettype wire

### src/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rgbc_ram #(
   parameter int WIDTH = rgbc_pkg::RGB_W,
   parameter int DEPTH = rgbc_pkg::RAM_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/rgbc_mac.sv
// One color channel: window products, row sums, total and clamp to 0..255.
`default_nettype none

module rgbc_mac #(
   parameter int KERNEL_SIZE = rgbc_pkg::KERNEL_SIZE_DEF,
   parameter int COEF_BITS   = rgbc_pkg::COEF_BITS_DEF
) (
   input  wire logic                                                      clock,
   input  wire rgbc_pkg::rgbc_pipe_en_type                                pipe_en,
   input  wire logic [KERNEL_SIZE*KERNEL_SIZE-1:0][rgbc_pkg::PIX_W-1:0]   win,
   input  wire logic [KERNEL_SIZE*KERNEL_SIZE-1:0][COEF_BITS-1:0]         coef,
   output logic      [rgbc_pkg::PIX_W-1:0]                                result
);

   import rgbc_pkg::*;

   localparam int KK     = KERNEL_SIZE * KERNEL_SIZE;
   localparam int PROD_W = PIX_W + 1 + COEF_BITS;
   localparam int GROW   = $clog2(KERNEL_SIZE) + 1;
   localparam int RSUM_W = PROD_W + GROW;
   localparam int TOT_W  = RSUM_W + GROW;
   localparam int Q_W    = TOT_W - FRAC_BITS;

   logic signed [PROD_W-1:0] prod_in  [KK];
   logic signed [PROD_W-1:0] prod_ff  [KK];
   logic signed [RSUM_W-1:0] rsum_in  [KERNEL_SIZE];
   logic signed [RSUM_W-1:0] rsum_ff  [KERNEL_SIZE];
   logic signed [TOT_W-1:0]  tot;
   logic        [Q_W-1:0]    quot;
   logic        [PIX_W-1:0]  result_in;
   logic        [PIX_W-1:0]  result_ff;

   // pixel times signed coefficient, one product per tap
   always_comb begin
      for (int i = 0; i < KK; i++) begin
         prod_in[i] = PROD_W'($signed({1'b0, win[i]})) * PROD_W'($signed(coef[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.s2) begin
         prod_ff <= prod_in;
      end
   end

   // sum each kernel row
   always_comb begin
      for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
         rsum_in[ky] = '0;
         for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
            rsum_in[ky] = rsum_in[ky] + RSUM_W'(prod_ff[ky*KERNEL_SIZE + kx]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.s3) begin
         rsum_ff <= rsum_in;
      end
   end

   // total, drop fraction (sum is positive here) and clamp
   always_comb begin
      tot = '0;
      for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
         tot = tot + TOT_W'(rsum_ff[ky]);
      end
      quot = tot[TOT_W-1:FRAC_BITS];
      if (tot[TOT_W-1] || (tot == '0)) begin
         result_in = '0;
      end else if (quot > Q_W'(PIX_MAX)) begin
         result_in = PIX_W'(PIX_MAX);
      end else begin
         result_in = quot[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.s4) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### src/rgb_2d_convolution_zero_pad_top.sv
// Top level of the streaming RGB convolution with zero padding.
//
//   channel | direction | transfer when          | payload
//   --------+-----------+------------------------+-----------------------------------------
//   req     | in        | req_valid && !req_stall| opcode, pix_red, pix_green, pix_blue
//   rsp     | out       | rsp_valid && !rsp_stall| out_red/green/blue, out_row/col, frame_last
//   csr     | in        | csr_write              | csr_index, csr_wdata
//
// One item per clock when not stalled. A result passes through the stage 1, product,
// row-sum and output registers; its window is read from (KERNEL_SIZE+1) x P RAM banks
// (P = KERNEL_SIZE rounded up to a power of two) in the cycle of the transfer that makes
// it ready, so every tap has a read port of its own. Synchronous active-high reset clears
// counters, registers and pipeline valids; the line store needs no clearing. A stalled
// output holds its register; earlier stages keep filling bubbles until the pipe is full.
`default_nettype none

module rgb_2d_convolution_zero_pad_top #(
   parameter int KERNEL_SIZE = rgbc_pkg::KERNEL_SIZE_DEF,
   parameter int MAX_WIDTH   = rgbc_pkg::MAX_WIDTH_DEF,
   parameter int COEF_BITS   = rgbc_pkg::COEF_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // pixel input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_opcode,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          req_pix_red,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          req_pix_green,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          req_pix_blue,
   // filtered output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [rgbc_pkg::PIX_W-1:0]          rsp_out_red,
   output logic      [rgbc_pkg::PIX_W-1:0]          rsp_out_green,
   output logic      [rgbc_pkg::PIX_W-1:0]          rsp_out_blue,
   output logic      [rgbc_pkg::ROW_W-1:0]          rsp_out_row,
   output logic      [rgbc_pkg::OUT_COL_W-1:0]      rsp_out_col,
   output logic                                     rsp_frame_last,
   // configuration
   input  wire logic                                csr_write,
   input  wire logic [rgbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rgbc_pkg::CFG_W-1:0]          csr_wdata
);

   import rgbc_pkg::*;

   localparam int HALF   = KERNEL_SIZE / 2;
   localparam int KK     = KERNEL_SIZE * KERNEL_SIZE;
   localparam int RING   = KERNEL_SIZE + 1;
   localparam int RING_W = $clog2(RING);
   localparam int LKP    = $clog2(KERNEL_SIZE);
   localparam int KP     = 1 << LKP;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int AW     = COL_W - LKP;

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0]                frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]                frame_height_ff, frame_height_in;
   logic [NUM_BANKS-1:0][CFG_W-1:0] kbank_ff, kbank_in;

   logic [COL_W:0]      lat_w_ff, lat_w_in;
   logic [ROW_W-1:0]    lat_h_ff, lat_h_in;
   logic                active_ff, active_in;
   logic [ROW_W-1:0]    in_row_ff, in_row_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [RING_W-1:0]   in_ring_ff, in_ring_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [RING_W-1:0]   out_ring_ff, out_ring_in;

   // ---------------------------------------------------------------- step decode
   logic                is_pix, starting, active_n, step_wr, accept, emit, load1;
   logic [COL_W:0]      new_w, lw, col_inc, col_lim, col_need, cc, oc_inc;
   logic [ROW_W-1:0]    new_h, lh;
   logic [ROW_W-1:0]    in_row_nx;
   logic [COL_W-1:0]    in_col_nx;
   logic [RING_W-1:0]   in_ring_nx;
   logic [ROW_W:0]      row_lim, row_need, rr, or_inc;
   logic                ready, frame_done;

   // pipeline control
   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic                en1, en2, en3, en4;
   rgbc_pipe_en_type    pipe_en;

   // window addressing
   logic [KERNEL_SIZE-1:0]                 row_ok, col_ok;
   logic [KERNEL_SIZE-1:0][RING_W-1:0]     ring_sel;
   logic [KERNEL_SIZE-1:0][LKP-1:0]        bank_sel;
   logic [KERNEL_SIZE-1:0][AW-1:0]         col_addr;
   logic [KP-1:0][AW-1:0]                  bank_addr;
   logic [RING-1:0][KP-1:0]                hit;
   logic [RGB_W-1:0]                       wr_data;
   logic [RGB_W-1:0]                       ram_rd [RING][KP];

   // stage 1 side registers
   logic [KERNEL_SIZE-1:0]                 s1_row_ok_ff, s1_col_ok_ff;
   logic [KERNEL_SIZE-1:0][RING_W-1:0]     s1_ring_sel_ff;
   logic [KERNEL_SIZE-1:0][LKP-1:0]        s1_bank_sel_ff;
   logic [RING-1:0][KP-1:0]                s1_hit_ff;
   logic [RGB_W-1:0]                       s1_wd_ff;
   logic [ROW_W-1:0]                       s1_row_ff, s2_row_ff, s3_row_ff, rsp_row_ff;
   logic [COL_W-1:0]                       s1_col_ff, s2_col_ff, s3_col_ff, rsp_col_ff;
   logic                                   s1_last_ff, s2_last_ff, s3_last_ff, rsp_last_ff;

   logic [KK-1:0][PIX_W-1:0]               red_win, green_win, blue_win;
   logic [KK-1:0][COEF_BITS-1:0]           coef_w;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      kbank_in        = kbank_ff;
      if (csr_write) begin
         unique case (csr_index) inside
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[DIM_W-1:0];
            CSR_BANK_A, CSR_BANK_B, CSR_BANK_C, CSR_BANK_D, CSR_BANK_E: begin
               kbank_in[CSR_IDX_W'(csr_index - CSR_BANK_A)] = csr_wdata;
            end
            default: ;
         endcase
      end
   end

   // coefficient slots, low COEF_BITS of each
   always_comb begin
      for (int i = 0; i < KK; i++) begin
         coef_w[i] = kbank_ff[i / SLOTS_PER_BANK][(i % SLOTS_PER_BANK) * SLOT_W +: COEF_BITS];
      end
   end

   // ---------------------------------------------------------------- handshake
   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = en4 || !v3_ff;
   assign en2       = en3 || !v2_ff;
   assign en1       = en2 || !v1_ff;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   assign pipe_en.s2 = en2;
   assign pipe_en.s3 = en3;
   assign pipe_en.s4 = en4;

   // ---------------------------------------------------------------- frame geometry
   always_comb begin
      if (frame_width_ff == '0) begin
         new_w = (COL_W+1)'(1);
      end else if ({1'b0, frame_width_ff} > (DIM_W+1)'(MAX_WIDTH)) begin
         new_w = (COL_W+1)'(MAX_WIDTH);
      end else begin
         new_w = (COL_W+1)'(frame_width_ff);
      end
      new_h    = (frame_height_ff == '0) ? ROW_W'(1) : frame_height_ff;
      is_pix   = (req_opcode == OP_PIXEL);
      starting = is_pix && !active_ff;
      lw       = starting ? new_w : lat_w_ff;
      lh       = starting ? new_h : lat_h_ff;
      active_n = active_ff || is_pix;
   end

   // input position after this item
   always_comb begin
      step_wr    = is_pix && (in_row_ff < lh);
      col_inc    = {1'b0, in_col_ff} + (COL_W+1)'(1);
      in_row_nx  = in_row_ff;
      in_col_nx  = in_col_ff;
      in_ring_nx = in_ring_ff;
      if (step_wr) begin
         if (col_inc >= lw) begin
            in_col_nx  = '0;
            in_row_nx  = in_row_ff + ROW_W'(1);
            in_ring_nx = (in_ring_ff == RING_W'(RING - 1)) ? '0 : in_ring_ff + RING_W'(1);
         end else begin
            in_col_nx = col_inc[COL_W-1:0];
         end
      end
   end

   // next output is ready once its last needed neighbor has arrived
   always_comb begin
      row_lim  = {1'b0, lh} - (ROW_W+1)'(1);
      row_need = {1'b0, out_row_ff} + (ROW_W+1)'(HALF);
      rr       = (row_need > row_lim) ? row_lim : row_need;
      col_lim  = lw - (COL_W+1)'(1);
      col_need = {1'b0, out_col_ff} + (COL_W+1)'(HALF);
      cc       = (col_need > col_lim) ? col_lim : col_need;
      ready    = ({1'b0, in_row_nx} > rr) ||
                 (({1'b0, in_row_nx} == rr) && ({1'b0, in_col_nx} > cc));
      emit     = active_n && ready;
      load1    = accept && emit;
      oc_inc   = {1'b0, out_col_ff} + (COL_W+1)'(1);
      or_inc   = {1'b0, out_row_ff} + (ROW_W+1)'(1);
      frame_done = (oc_inc >= lw) && (or_inc >= {1'b0, lh});
   end

   // counter and frame state next values
   always_comb begin
      lat_w_in    = lat_w_ff;
      lat_h_in    = lat_h_ff;
      active_in   = active_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_ring_in  = in_ring_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_ring_in = out_ring_ff;
      if (accept) begin
         lat_w_in   = lw;
         lat_h_in   = lh;
         active_in  = active_n;
         in_row_in  = in_row_nx;
         in_col_in  = in_col_nx;
         in_ring_in = in_ring_nx;
         if (emit) begin
            if (frame_done) begin
               // frame complete: everything back to the start
               active_in   = 1'b0;
               in_row_in   = '0;
               in_col_in   = '0;
               in_ring_in  = '0;
               out_row_in  = '0;
               out_col_in  = '0;
               out_ring_in = '0;
            end else if (oc_inc >= lw) begin
               out_col_in  = '0;
               out_row_in  = or_inc[ROW_W-1:0];
               out_ring_in = (out_ring_ff == RING_W'(RING - 1)) ? '0
                                                                : out_ring_ff + RING_W'(1);
            end else begin
               out_col_in = oc_inc[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         kbank_ff        <= '0;
         lat_w_ff        <= (COL_W+1)'(1);
         lat_h_ff        <= ROW_W'(1);
         active_ff       <= 1'b0;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         in_ring_ff      <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         out_ring_ff     <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         kbank_ff        <= kbank_in;
         lat_w_ff        <= lat_w_in;
         lat_h_ff        <= lat_h_in;
         active_ff       <= active_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         in_ring_ff      <= in_ring_in;
         out_row_ff      <= out_row_in;
         out_col_ff      <= out_col_in;
         out_ring_ff     <= out_ring_in;
      end
   end

   // ---------------------------------------------------------------- window addressing
   // rows: ring slot and in-frame test per kernel row
   always_comb begin
      logic [ROW_W:0]    rsum;
      logic [RING_W:0]   rt;
      for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
         rsum = {1'b0, out_row_ff} + (ROW_W+1)'(ky);
         row_ok[ky] = (rsum >= (ROW_W+1)'(HALF)) &&
                      ((rsum - (ROW_W+1)'(HALF)) < {1'b0, lh});
         rt = {1'b0, out_ring_ff} + (RING_W+1)'((ky + RING - HALF) % RING);
         ring_sel[ky] = (rt >= (RING_W+1)'(RING)) ? RING_W'(rt - (RING_W+1)'(RING))
                                                  : RING_W'(rt);
      end
   end

   // columns: bank, address and in-frame test per kernel column
   always_comb begin
      logic [COL_W:0] csum;
      logic [COL_W:0] xc;
      for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
         csum = {1'b0, out_col_ff} + (COL_W+1)'(kx);
         xc   = csum - (COL_W+1)'(HALF);
         col_ok[kx]   = (csum >= (COL_W+1)'(HALF)) && (xc < lw);
         bank_sel[kx] = xc[LKP-1:0];
         col_addr[kx] = xc[COL_W-1:LKP];
      end
   end

   // one read address per column bank; taps fall in distinct banks
   always_comb begin
      for (int j = 0; j < KP; j++) begin
         bank_addr[j] = '0;
         for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
            if (bank_sel[kx] == LKP'(j)) begin
               bank_addr[j] = col_addr[kx];
            end
         end
      end
   end

   // same-cycle write to an entry being read: forward the new pixel
   always_comb begin
      for (int g = 0; g < RING; g++) begin
         for (int j = 0; j < KP; j++) begin
            hit[g][j] = step_wr && (in_ring_ff == RING_W'(g)) &&
                        (in_col_ff[LKP-1:0] == LKP'(j)) &&
                        (in_col_ff[COL_W-1:LKP] == bank_addr[j]);
         end
      end
   end

   assign wr_data = {req_pix_red, req_pix_green, req_pix_blue};

   // ---------------------------------------------------------------- line store banks
   for (genvar g = 0; g < RING; g++) begin : g_ring
      for (genvar j = 0; j < KP; j++) begin : g_bank
         rgbc_ram #(
            .WIDTH (RGB_W),
            .DEPTH (1 << AW)
         ) u_ram (
            .clock   (clock),
            .wr_en   (accept && step_wr && (in_ring_ff == RING_W'(g)) &&
                      (in_col_ff[LKP-1:0] == LKP'(j))),
            .wr_addr (in_col_ff[COL_W-1:LKP]),
            .wr_data (wr_data),
            .rd_en   (load1),
            .rd_addr (bank_addr[j]),
            .rd_data (ram_rd[g][j])
         );
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (load1) begin
         s1_row_ok_ff   <= row_ok;
         s1_col_ok_ff   <= col_ok;
         s1_ring_sel_ff <= ring_sel;
         s1_bank_sel_ff <= bank_sel;
         s1_hit_ff      <= hit;
         s1_wd_ff       <= wr_data;
         s1_row_ff      <= out_row_ff;
         s1_col_ff      <= out_col_ff;
         s1_last_ff     <= (out_row_ff == ROW_W'(lh - ROW_W'(1))) &&
                           ({1'b0, out_col_ff} == col_lim);
      end
   end

   // gather taps, zero outside the frame
   always_comb begin
      logic [RGB_W-1:0] pix;
      for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
         for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
            if (s1_hit_ff[s1_ring_sel_ff[ky]][s1_bank_sel_ff[kx]]) begin
               pix = s1_wd_ff;
            end else begin
               pix = ram_rd[s1_ring_sel_ff[ky]][s1_bank_sel_ff[kx]];
            end
            if (!(s1_row_ok_ff[ky] && s1_col_ok_ff[kx])) begin
               pix = '0;
            end
            red_win[ky*KERNEL_SIZE + kx]   = pix[3*PIX_W-1:2*PIX_W];
            green_win[ky*KERNEL_SIZE + kx] = pix[2*PIX_W-1:PIX_W];
            blue_win[ky*KERNEL_SIZE + kx]  = pix[PIX_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- MAC channels
   rgbc_mac #(.KERNEL_SIZE(KERNEL_SIZE), .COEF_BITS(COEF_BITS)) u_mac_red (
      .clock   (clock),
      .pipe_en (pipe_en),
      .win     (red_win),
      .coef    (coef_w),
      .result  (rsp_out_red)
   );

   rgbc_mac #(.KERNEL_SIZE(KERNEL_SIZE), .COEF_BITS(COEF_BITS)) u_mac_green (
      .clock   (clock),
      .pipe_en (pipe_en),
      .win     (green_win),
      .coef    (coef_w),
      .result  (rsp_out_green)
   );

   rgbc_mac #(.KERNEL_SIZE(KERNEL_SIZE), .COEF_BITS(COEF_BITS)) u_mac_blue (
      .clock   (clock),
      .pipe_en (pipe_en),
      .win     (blue_win),
      .coef    (coef_w),
      .result  (rsp_out_blue)
   );

   // ---------------------------------------------------------------- position pipeline
   always_ff @(posedge clock) begin
      if (en2) begin
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (en3) begin
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_last_ff <= s2_last_ff;
      end
      if (en4) begin
         rsp_row_ff  <= s3_row_ff;
         rsp_col_ff  <= s3_col_ff;
         rsp_last_ff <= s3_last_ff;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= load1;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = OUT_COL_W'(rsp_col_ff);
   assign rsp_frame_last = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   // input never runs past the last row of the frame
   a_in_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (in_row_ff <= lat_h_ff))
      else $error("input row beyond frame height");

   // pending output position stays inside the frame
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ((out_row_ff < lat_h_ff) && ({1'b0, out_col_ff} < lat_w_ff)))
      else $error("output position outside frame");

   // between frames all counters sit at zero
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> ((in_row_ff == '0) && (in_col_ff == '0) &&
                      (out_row_ff == '0) && (out_col_ff == '0)))
      else $error("counters not cleared between frames");

   // a stalled stage 1 issues no new window read
   a_hold_read: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !en2) |-> !load1)
      else $error("window read while stage 1 holds");

endmodule

`default_nettype wire

### tb/rgbc_scoreboard.sv
// Predicts filtered pixels from observed transfers and checks the block's results.
`timescale 1ns / 100ps

module rgbc_scoreboard (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_opcode,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          req_pix_red,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          req_pix_green,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          req_pix_blue,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          rsp_out_red,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          rsp_out_green,
   input  wire logic [rgbc_pkg::PIX_W-1:0]          rsp_out_blue,
   input  wire logic [rgbc_pkg::ROW_W-1:0]          rsp_out_row,
   input  wire logic [rgbc_pkg::OUT_COL_W-1:0]      rsp_out_col,
   input  wire logic                                rsp_frame_last,
   input  wire logic                                csr_write,
   input  wire logic [rgbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rgbc_pkg::CFG_W-1:0]          csr_wdata,
   output int                                       fail_count,
   output int                                       results_owed,
   output logic                                     frame_open
);
   import rgbc_pkg::*;

   localparam int K     = KERNEL_SIZE_DEF;
   localparam int HALF  = K / 2;
   localparam int RING  = K + 1;
   localparam int MAXW  = MAX_WIDTH_DEF;

   typedef struct packed {
      logic [PIX_W-1:0]     red;
      logic [PIX_W-1:0]     green;
      logic [PIX_W-1:0]     blue;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } filtered_pixel_type;

   // shadow of the block's line buffer and frame counters
   logic [RGB_W-1:0] line_mem [RING][MAXW];
   int unsigned      in_row, in_col, out_row, out_col, lat_w, lat_h;
   bit               frame_on;
   logic [DIM_W-1:0] width_reg, height_reg;
   logic [CFG_W-1:0] bank [NUM_BANKS];

   filtered_pixel_type pending_pixels [$];

   function automatic int coef_at(int i);
      logic [CFG_W-1:0]  word;
      logic [SLOT_W-1:0] slot;
      word = bank[i / SLOTS_PER_BANK] >> (SLOT_W * (i % SLOTS_PER_BANK));
      slot = word[SLOT_W-1:0];
      return int'($signed(slot));
   endfunction

   function automatic logic [PIX_W-1:0] clamp_pixel(int s);
      if (s <= 0) return '0;
      s = s >>> FRAC_BITS;
      return (s > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(s);
   endfunction

   function automatic bit window_ready();
      int unsigned rr, cc;
      rr = out_row + HALF;
      cc = out_col + HALF;
      if (rr > lat_h - 1) rr = lat_h - 1;
      if (cc > lat_w - 1) cc = lat_w - 1;
      return (in_row > rr) || (in_row == rr && in_col > cc);
   endfunction

   // one accepted input transfer: store pixel, then emit at most one filtered pixel
   task automatic absorb_item(logic op, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b);
      int              acc [3];
      int              y, x, k;
      logic [RGB_W-1:0] p;
      filtered_pixel_type res;
      if (op == OP_PIXEL) begin
         if (!frame_on) begin
            lat_w    = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
            lat_h    = (height_reg == 0) ? 1 : height_reg;
            frame_on = 1'b1;
         end
         if (in_row < lat_h) begin
            line_mem[in_row % RING][in_col] = {r, g, b};
            in_col++;
            if (in_col >= lat_w) begin
               in_col = 0;
               in_row++;
            end
         end
      end
      if (!frame_on || !window_ready()) return;
      acc = '{0, 0, 0};
      for (int ky = 0; ky < K; ky++) begin
         y = int'(out_row) + ky - HALF;
         if (y < 0 || y >= int'(lat_h)) continue;
         for (int kx = 0; kx < K; kx++) begin
            x = int'(out_col) + kx - HALF;
            if (x < 0 || x >= int'(lat_w)) continue;
            p = line_mem[y % RING][x];
            k = coef_at(ky * K + kx);
            acc[0] += int'(p[23:16]) * k;
            acc[1] += int'(p[15:8]) * k;
            acc[2] += int'(p[7:0]) * k;
         end
      end
      res.red   = clamp_pixel(acc[0]);
      res.green = clamp_pixel(acc[1]);
      res.blue  = clamp_pixel(acc[2]);
      res.row   = ROW_W'(out_row);
      res.col   = OUT_COL_W'(out_col);
      res.last  = (out_row == lat_h - 1) && (out_col == lat_w - 1);
      pending_pixels.push_back(res);
      out_col++;
      if (out_col >= lat_w) begin
         out_col = 0;
         out_row++;
         if (out_row >= lat_h) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            frame_on = 1'b0;
         end
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   // watch all three ports at the rising edge
   always @(posedge clock) begin
      filtered_pixel_type want;
      if (reset) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         lat_w = 1; lat_h = 1; frame_on = 1'b0;
         width_reg = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         for (int i = 0; i < NUM_BANKS; i++) bank[i] = '0;
         pending_pixels.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg  = csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT: height_reg = csr_wdata[DIM_W-1:0];
               CSR_BANK_A:       bank[0]    = csr_wdata;
               CSR_BANK_B:       bank[1]    = csr_wdata;
               CSR_BANK_C:       bank[2]    = csr_wdata;
               CSR_BANK_D:       bank[3]    = csr_wdata;
               CSR_BANK_E:       bank[4]    = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $error("result transfer with no result expected (row %0d col %0d)",
                      rsp_out_row, rsp_out_col);
               fail_count++;
            end else begin
               want = pending_pixels.pop_front();
               check_field("out_red", want.red, rsp_out_red);
               check_field("out_green", want.green, rsp_out_green);
               check_field("out_blue", want.blue, rsp_out_blue);
               check_field("out_row", want.row, rsp_out_row);
               check_field("out_col", want.col, rsp_out_col);
               check_field("frame_last", want.last, rsp_frame_last);
            end
         end
         if (req_valid && !req_stall)
            absorb_item(req_opcode, req_pix_red, req_pix_green, req_pix_blue);
      end
      results_owed <= pending_pixels.size();
      frame_open   <= frame_on;
   end

endmodule

### tb/rgb_2d_convolution_zero_pad_top_tb.sv
// Stimulus and verdict for the RGB zero-padded convolution block.
`timescale 1ns / 100ps

module rgb_2d_convolution_zero_pad_top_tb;
   import rgbc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_PIXELS = 1000;
   localparam int QUIET_PIXELS  = 250;
   localparam int TALL_ROWS     = 400;

   logic                 clock, reset;
   logic                 req_valid, req_stall, req_opcode;
   logic [PIX_W-1:0]     req_pix_red, req_pix_green, req_pix_blue;
   logic                 rsp_valid, rsp_stall;
   logic [PIX_W-1:0]     rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [ROW_W-1:0]     rsp_out_row;
   logic [OUT_COL_W-1:0] rsp_out_col;
   logic                 rsp_frame_last;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   int   fail_count, results_owed, cycles;
   logic frame_open;
   bit   quiet;
   int   width_eff, height_eff;

   rgb_2d_convolution_zero_pad_top i_dut (.*);

   rgbc_scoreboard i_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("rgb_2d_convolution_zero_pad_top regression: fail");
         $finish;
      end
   end

   // output back-pressure in random bursts, none in the quiet tail
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= (!quiet && $urandom_range(0, 2) == 0);
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   // one input transfer, with an occasional gap before it
   task automatic send_item(logic op, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_pix_red   <= r;
      req_pix_green <= g;
      req_pix_blue  <= b;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [PIX_W-1:0] rand_channel();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel();
      send_item(OP_PIXEL, rand_channel(), rand_channel(), rand_channel());
   endtask

   // push out the trailing results with drains and dropped pixels
   task automatic flush_frame();
      forever begin
         @(negedge clock);
         if (!frame_open) begin
            req_valid <= 1'b0;
            break;
         end
         if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         req_valid     <= 1'b1;
         req_opcode    <= ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN;
         req_pix_red   <= rand_channel();
         req_pix_green <= rand_channel();
         req_pix_blue  <= rand_channel();
         do @(posedge clock); while (req_stall);
      end
   endtask

   // sender holds off until every result is back and the pipe has emptied
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_frame(int w, int h);
      write_reg(CSR_FRAME_WIDTH, CFG_W'(w));
      write_reg(CSR_FRAME_HEIGHT, CFG_W'(h));
      width_eff  = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
      height_eff = (h == 0) ? 1 : h;
   endtask

   // bank with the same coefficient in all five slots
   function automatic logic [CFG_W-1:0] fill_bank(logic [SLOT_W-1:0] coef);
      return {SLOTS_PER_BANK{coef}};
   endfunction

   function automatic logic [CFG_W-1:0] rand_bank();
      logic [CFG_W-1:0] word;
      int               mode;
      word = '0;
      for (int s = 0; s < SLOTS_PER_BANK; s++) begin
         mode = $urandom_range(0, 9);
         if (mode < 2)
            word[SLOT_W*s +: SLOT_W] = SLOT_W'($urandom);
         else if (mode == 2)
            word[SLOT_W*s +: SLOT_W] = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
         else
            word[SLOT_W*s +: SLOT_W] = SLOT_W'($urandom_range(0, 110) - 48);
      end
      return word;
   endfunction

   task automatic rand_kernel();
      write_reg(CSR_BANK_A, rand_bank());
      write_reg(CSR_BANK_B, rand_bank());
      write_reg(CSR_BANK_C, CFG_W'({$urandom, $urandom}));
      write_reg(CSR_BANK_D, CFG_W'({$urandom, $urandom}));
      write_reg(CSR_BANK_E, CFG_W'({$urandom, $urandom}));
   endtask

   task automatic run_frame(int noise_pct);
      for (int i = 0; i < width_eff * height_eff; i++) begin
         if ($urandom_range(1, 100) <= noise_pct)
            send_item(OP_DRAIN, rand_channel(), rand_channel(), rand_channel());
         send_pixel();
      end
      flush_frame();
   endtask

   initial begin
      int random_pixels;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = OP_PIXEL;
      req_pix_red = '0; req_pix_green = '0; req_pix_blue = '0;
      csr_write  = 1'b0;
      csr_index  = CSR_FRAME_WIDTH;
      csr_wdata  = '0;
      quiet      = 1'b0;
      width_eff  = MAX_WIDTH_DEF;
      height_eff = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: drain with nothing in flight
      send_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      settle();

      // identity kernel (center tap 1.0) on a 3x3 frame that opens with extreme pixels
      set_frame(3, 3);
      write_reg(CSR_BANK_A, CFG_W'(12'h100) << (SLOT_W * 4));
      write_reg(CSR_BANK_B, '0);
      write_reg(CSR_BANK_C, {CFG_W{1'b1}});
      write_reg(CSR_BANK_D, '0);
      write_reg(CSR_BANK_E, {CFG_W{1'b1}});
      send_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
      send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
      for (int i = 0; i < 7; i++) send_pixel();
      send_item(OP_PIXEL, 8'hAA, 8'h55, 8'hAA);   // dropped, acts as drain
      flush_frame();
      settle();

      // largest positive taps saturate high
      set_frame(2, 2);
      write_reg(CSR_BANK_A, fill_bank(12'h7FF));
      write_reg(CSR_BANK_B, fill_bank(12'h7FF));
      for (int i = 0; i < 4; i++) send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      flush_frame();
      settle();

      // most negative taps clamp to zero; zero sizes count as one
      set_frame(0, 0);
      write_reg(CSR_BANK_A, fill_bank(12'h800));
      write_reg(CSR_BANK_B, fill_bank(12'h800));
      send_item(OP_PIXEL, 8'hFF, 8'h80, 8'h01);
      flush_frame();
      settle();

      // tall narrow frame wraps the row ring many times
      rand_kernel();
      set_frame(1, TALL_ROWS);
      run_frame(0);
      settle();

      // random frames, mostly small; the quiet tail repeats the last setup back to back
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels > RANDOM_PIXELS - QUIET_PIXELS) quiet = 1'b1;
         if (!quiet) begin
            if ($urandom_range(0, 2) == 0) rand_kernel();
            set_frame($urandom_range(1, 12), $urandom_range(1, 8));
         end
         run_frame(10);
         random_pixels += width_eff * height_eff;
         if (!quiet) settle();
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("rgb_2d_convolution_zero_pad_top regression: pass");
      else
         $display("rgb_2d_convolution_zero_pad_top regression: fail");
      $finish;
   end

endmodule
